FILE: src/dlpg_pkg.sv
// Package for the DDA line point generator.
// Holds default widths, operation codes and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dlpg_pkg;

    // Default coordinate and fraction widths
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 8;

    // Operation codes of an input item
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;      // load item accepted
        logic step;      // step item accepted
        logic div_step;  // one restoring division step
        logic div_last;  // final division step, write slope
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic needs_div; // loaded endpoints differ in x
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: src/dlpg_ctrl.sv
// Controller of the DDA line point generator: handshake, idle/divide FSM,
// division step counter and output valid flag. Depends on dlpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dlpg_ctrl
    import dlpg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire logic    i_operation,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    localparam int NW = COORD_BITS + FRAC_BITS;   // dividend width
    localparam int CW = $clog2(NW);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    logic          r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    logic          out_free;
    logic          accept;
    logic          cnt_last;

    // Handshake: output slot frees when empty or being taken
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE) || !out_free;
    assign accept     = i_in_valid && !o_in_stall;
    assign cnt_last   = (r_cnt == CW'(NW - 1));

    // Commands
    always_comb begin
        o_cmd.load     = accept && (i_operation == OP_LOAD);
        o_cmd.step     = accept && (i_operation == OP_STEP);
        o_cmd.div_step = (r_state == ST_DIV);
        o_cmd.div_last = (r_state == ST_DIV) && cnt_last;
    end

    // State machine and division counter
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.load && i_sts.needs_div) begin
                    n_state = ST_DIV;
                    n_cnt   = '0;
                end
            end
            ST_DIV: begin
                n_cnt = r_cnt + CW'(1);
                if (cnt_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // Checks
    a_div_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> o_in_stall)
        else $error("input accepted during division");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_cnt <= CW'(NW - 1)))
        else $error("division counter out of range");

    a_load_enters_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load && i_sts.needs_div) |=> (r_state == ST_DIV && r_cnt == '0))
        else $error("sloped load did not start division");

    a_div_ends_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_last |=> (r_state == ST_IDLE))
        else $error("division did not end");

endmodule

`default_nettype wire

FILE: src/dlpg_datapath.sv
// Datapath of the DDA line point generator: endpoint ordering, restoring
// slope divider, walk registers and output payload. Depends on dlpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dlpg_datapath
    import dlpg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire t_dp_cmd                             i_cmd,
    output t_dp_sts                                  o_sts,
    input  wire logic signed [COORD_BITS-1:0]        i_x_start,
    input  wire logic signed [COORD_BITS-1:0]        i_y_start,
    input  wire logic signed [COORD_BITS-1:0]        i_x_end,
    input  wire logic signed [COORD_BITS-1:0]        i_y_end,
    output logic                                     o_point_valid,
    output logic signed [COORD_BITS-1:0]             o_point_x,
    output logic signed [COORD_BITS+FRAC_BITS-1:0]   o_point_y_fixed,
    output logic [COORD_BITS-1:0]                    o_point_index,
    output logic                                     o_last
);

    localparam int C  = COORD_BITS;
    localparam int YF = COORD_BITS + FRAC_BITS;
    localparam int NW = COORD_BITS + FRAC_BITS;

    // Walk state
    logic signed [C-1:0]  r_x;
    logic signed [YF-1:0] r_y;
    logic signed [NW:0]   r_slope;
    logic                 r_vert;
    logic [C-1:0]         r_left;
    logic [C-1:0]         r_index;

    // Divider state
    logic [NW-1:0] r_quo, n_quo;
    logic [C-1:0]  r_rem, n_rem;
    logic [C-1:0]  r_dvs;
    logic          r_neg;

    // Output payload
    logic                 r_o_valid;
    logic signed [C-1:0]  r_o_x;
    logic signed [YF-1:0] r_o_y;
    logic [C-1:0]         r_o_index;
    logic                 r_o_last;

    // Load: order endpoints and derive spans
    logic                 vert_in, swap;
    logic signed [C-1:0]  lo_x, lo_y, hi_x, hi_y;
    logic signed [C:0]    dx, dy;
    logic [C-1:0]         dy_mag, span, ld_left;
    logic signed [YF-1:0] ld_y;

    always_comb begin
        vert_in = (i_x_start == i_x_end);
        swap    = vert_in ? (i_y_start > i_y_end) : (i_x_start > i_x_end);
        lo_x    = swap ? i_x_end   : i_x_start;
        lo_y    = swap ? i_y_end   : i_y_start;
        hi_x    = swap ? i_x_start : i_x_end;
        hi_y    = swap ? i_y_start : i_y_end;
        dx      = (C+1)'(hi_x) - (C+1)'(lo_x);
        dy      = (C+1)'(hi_y) - (C+1)'(lo_y);
        dy_mag  = dy[C] ? C'(-dy) : C'(dy);
        span    = vert_in ? C'(dy) : C'(dx);
        ld_left = (span >= C'(2)) ? (span - C'(1)) : '0;
        ld_y    = YF'(lo_y) <<< FRAC_BITS;
    end

    assign o_sts.needs_div = !vert_in;

    // One restoring division step
    logic [C:0] trial;
    logic       q_bit;

    always_comb begin
        trial = {r_rem, r_quo[NW-1]};
        q_bit = (trial >= {1'b0, r_dvs});
        n_rem = q_bit ? C'(trial - {1'b0, r_dvs}) : trial[C-1:0];
        n_quo = {r_quo[NW-2:0], q_bit};
    end

    // Step: advance one unit in x, or in y for a vertical line
    logic                 have_pt;
    logic signed [C-1:0]  st_x;
    logic signed [YF-1:0] st_y;
    logic [C-1:0]         st_left, st_index;

    always_comb begin
        have_pt  = (r_left != '0);
        st_x     = r_vert ? r_x : (r_x + C'(1));
        st_y     = r_vert ? (r_y + (YF'(1) << FRAC_BITS)) : (r_y + r_slope[YF-1:0]);
        st_left  = r_left - C'(1);
        st_index = r_index + C'(1);
    end

    // Walk and slope registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x     <= '0;
            r_y     <= '0;
            r_slope <= '0;
            r_vert  <= 1'b0;
            r_left  <= '0;
            r_index <= '0;
        end else if (i_cmd.load) begin
            r_x     <= lo_x;
            r_y     <= ld_y;
            r_slope <= '0;
            r_vert  <= vert_in;
            r_left  <= ld_left;
            r_index <= '0;
        end else if (i_cmd.step && have_pt) begin
            r_x     <= st_x;
            r_y     <= st_y;
            r_left  <= st_left;
            r_index <= st_index;
        end else if (i_cmd.div_last) begin
            r_slope <= r_neg ? -$signed({1'b0, n_quo}) : $signed({1'b0, n_quo});
        end
    end

    // Divider registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quo <= NW'(dy_mag) << FRAC_BITS;
            r_rem <= '0;
            r_dvs <= C'(dx);
            r_neg <= dy[C];
        end else if (i_cmd.div_step) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    // Output payload, written when an item is accepted
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_o_valid <= 1'b0;
            r_o_x     <= '0;
            r_o_y     <= '0;
            r_o_index <= '0;
            r_o_last  <= (ld_left == '0);
        end else if (i_cmd.step) begin
            r_o_valid <= have_pt;
            r_o_x     <= have_pt ? st_x : '0;
            r_o_y     <= have_pt ? st_y : '0;
            r_o_index <= have_pt ? st_index : '0;
            r_o_last  <= have_pt ? (st_left == '0) : 1'b1;
        end
    end

    assign o_point_valid   = r_o_valid;
    assign o_point_x       = r_o_x;
    assign o_point_y_fixed = r_o_y;
    assign o_point_index   = r_o_index;
    assign o_last          = r_o_last;

endmodule

`default_nettype wire

FILE: src/dda_line_point_generator_core.sv
// Top level of the DDA line point generator.
// Instantiates dlpg_ctrl and dlpg_datapath; depends on dlpg_pkg.
//
//  Channel | Handshake                 | Payload
//  --------+---------------------------+----------------------------------------------
//  input   | i_in_valid / o_in_stall   | i_operation, i_x_start, i_y_start, i_x_end, i_y_end
//  output  | o_out_valid / i_out_stall | o_point_valid, o_point_x, o_point_y_fixed,
//          |                           | o_point_index, o_last
//
// Step items stream at one item per cycle while the output is not stalled.
// A load of a line that is not vertical runs a restoring divider one quotient
// bit per cycle, during which input is stalled; its result item is issued at
// once. Vertical loads do not run the divider.
// Reset is synchronous, active low, and clears the line state (no line loaded).
// The output register holds a result under i_out_stall; input is taken while
// that result is being taken.
`timescale 1ns / 1ps
`default_nettype none

module dda_line_point_generator_core
    import dlpg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_operation,
    input  wire logic signed [COORD_BITS-1:0]      i_x_start,
    input  wire logic signed [COORD_BITS-1:0]      i_y_start,
    input  wire logic signed [COORD_BITS-1:0]      i_x_end,
    input  wire logic signed [COORD_BITS-1:0]      i_y_end,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic                                   o_point_valid,
    output logic signed [COORD_BITS-1:0]           o_point_x,
    output logic signed [COORD_BITS+FRAC_BITS-1:0] o_point_y_fixed,
    output logic [COORD_BITS-1:0]                  o_point_index,
    output logic                                   o_last
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    dlpg_ctrl #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    dlpg_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_x_start       (i_x_start),
        .i_y_start       (i_y_start),
        .i_x_end         (i_x_end),
        .i_y_end         (i_y_end),
        .o_point_valid   (o_point_valid),
        .o_point_x       (o_point_x),
        .o_point_y_fixed (o_point_y_fixed),
        .o_point_index   (o_point_index),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire
